@@ rtl/core/qbs_pkg.sv @@
package qbs_pkg;

   localparam int DEF_STACK_SLOTS = 16;
   localparam int DEF_STACK_DEPTH = 16;

   localparam int LIMIT_W = 5;
   localparam int DEST_W  = 8;
   localparam int VALUE_W = 32;
   localparam int ITEM_W  = DEST_W + VALUE_W;
   localparam int CSR_W   = 32;
   localparam int PADDR_W = 3;

   localparam logic [LIMIT_W-1:0] RESET_MAX_STACKS = 5'd16;
   localparam logic [LIMIT_W-1:0] RESET_MAX_HEIGHT = 5'd16;

   // paddr[2] selects the register
   localparam logic REG_MAX_STACKS = 1'b0;
   localparam logic REG_MAX_HEIGHT = 1'b1;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_SHIP  = 1'b1;

   typedef struct packed {
      logic accepted;
      logic shipped;
      logic is_empty;
      logic is_full;
   } status_type;

endpackage

@@ rtl/core/qbs_mem.sv @@
module qbs_mem #(
   parameter int ADDR_W = 8,
   parameter int WORDS  = 256
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic                       re,
   input  logic [ADDR_W-1:0]          addr,
   input  logic [qbs_pkg::ITEM_W-1:0] wdata,
   output logic [qbs_pkg::ITEM_W-1:0] rdata
);
   import qbs_pkg::*;

   logic [ITEM_W-1:0] mem_ff [WORDS];
   logic [ITEM_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/qbs_ctrl.sv @@
module qbs_ctrl #(
   parameter int STACK_SLOTS = qbs_pkg::DEF_STACK_SLOTS,
   parameter int STACK_DEPTH = qbs_pkg::DEF_STACK_DEPTH,
   parameter int ADDR_W      = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   input  logic                        op_cmd,
   input  logic [qbs_pkg::LIMIT_W-1:0] max_stacks,
   input  logic [qbs_pkg::LIMIT_W-1:0] max_height,
   output logic                        mem_we,
   output logic                        mem_re,
   output logic [ADDR_W-1:0]           mem_addr,
   output qbs_pkg::status_type         status
);
   import qbs_pkg::*;

   localparam int IDX_W  = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
   localparam int CNT_W  = $clog2(STACK_SLOTS + 1);
   localparam int FILL_W = $clog2(STACK_DEPTH + 1);
   localparam int SL_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int HL_W   = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STACK_SLOTS - 1);

   logic [IDX_W-1:0]  front_ff, front_in, back_ff, back_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [FILL_W-1:0] front_fill_ff, front_fill_in, back_fill_ff, back_fill_in;
   logic [FILL_W-1:0] fill_ff [STACK_SLOTS];
   status_type        status_ff, status_in;

   logic [SL_W-1:0]   slim;
   logic [HL_W-1:0]   hlim;
   logic              back_full, empty_now, full_now, do_store, do_ship;
   logic [IDX_W-1:0]  back_inc, front_inc, new_back, fill_idx, addr_idx;
   logic [FILL_W-1:0] nf, fill_wd, addr_fill;
   logic              fill_we;

   always_comb begin
      if (max_stacks == '0) begin
         slim = SL_W'(1);
      end else if (SL_W'(max_stacks) > SL_W'(STACK_SLOTS)) begin
         slim = SL_W'(STACK_SLOTS);
      end else begin
         slim = SL_W'(max_stacks);
      end
      if (max_height == '0) begin
         hlim = HL_W'(1);
      end else if (HL_W'(max_height) > HL_W'(STACK_DEPTH)) begin
         hlim = HL_W'(STACK_DEPTH);
      end else begin
         hlim = HL_W'(max_height);
      end
   end

   assign back_full = HL_W'(back_fill_ff) >= hlim;
   assign empty_now = (count_ff == '0);
   assign full_now  = !empty_now && (SL_W'(count_ff) >= slim) && back_full;
   assign do_store  = op_valid && (op_cmd == CMD_STORE) && !full_now;
   assign do_ship   = op_valid && (op_cmd == CMD_SHIP) && !empty_now;
   assign back_inc  = (back_ff == LAST_IDX) ? '0 : back_ff + IDX_W'(1);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_W'(1);
   assign new_back  = empty_now ? front_ff : back_inc;
   assign nf        = (front_fill_ff != '0) ? front_fill_ff - FILL_W'(1) : '0;

   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      front_fill_in = front_fill_ff;
      back_fill_in  = back_fill_ff;
      fill_we       = 1'b0;
      fill_idx      = back_ff;
      fill_wd       = back_fill_ff;
      addr_idx      = back_ff;
      addr_fill     = back_fill_ff;
      if (do_store) begin
         fill_we = 1'b1;
         if (empty_now || back_full) begin
            back_in      = new_back;
            count_in     = count_ff + CNT_W'(1);
            back_fill_in = FILL_W'(1);
            if (empty_now) begin
               front_fill_in = FILL_W'(1);
            end
            fill_idx  = new_back;
            fill_wd   = FILL_W'(1);
            addr_idx  = new_back;
            addr_fill = '0;
         end else begin
            back_fill_in = back_fill_ff + FILL_W'(1);
            fill_wd      = back_fill_ff + FILL_W'(1);
            if (count_ff == CNT_W'(1)) begin
               front_fill_in = back_fill_ff + FILL_W'(1);
            end
         end
      end else if (do_ship) begin
         fill_we   = 1'b1;
         fill_idx  = front_ff;
         fill_wd   = nf;
         addr_idx  = front_ff;
         addr_fill = nf;
         if (nf == '0) begin
            front_in      = front_inc;
            count_in      = count_ff - CNT_W'(1);
            front_fill_in = fill_ff[front_inc];
         end else begin
            front_fill_in = nf;
            if (count_ff == CNT_W'(1)) begin
               back_fill_in = nf;
            end
         end
      end
   end

   always_comb begin
      status_in.accepted = do_store || do_ship;
      status_in.shipped  = do_ship;
      status_in.is_empty = (count_in == '0);
      status_in.is_full  = (count_in != '0) && (SL_W'(count_in) >= slim)
                           && (HL_W'(back_fill_in) >= hlim);
   end

   assign mem_we   = do_store;
   assign mem_re   = do_ship;
   assign mem_addr = ADDR_W'(addr_idx) * ADDR_W'(STACK_DEPTH) + ADDR_W'(addr_fill);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         back_ff       <= '0;
         count_ff      <= '0;
         front_fill_ff <= '0;
         back_fill_ff  <= '0;
         status_ff     <= '0;
         for (int i = 0; i < STACK_SLOTS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         front_ff      <= front_in;
         back_ff       <= back_in;
         count_ff      <= count_in;
         front_fill_ff <= front_fill_in;
         back_fill_ff  <= back_fill_in;
         if (op_valid) begin
            status_ff <= status_in;
         end
         if (fill_we) begin
            fill_ff[fill_idx] <= fill_wd;
         end
      end
   end

   assign status = status_ff;

endmodule

@@ rtl/core/queue_of_bounded_stacks.sv @@
// Queue of bounded stacks: a FIFO ring of stacks of 40-bit items
// (8-bit destination, 32-bit value).
// Command channel: an item is taken when start is high and busy is low.
// busy stays low, so one item may be issued in every cycle.
// req_command selects store (push onto the back stack, opening a new stack
// when it is full) or ship (pop the top of the front stack, retiring it
// once empty).
// Result channel: exactly one result per item, shown for one cycle with
// rsp_valid high, in the cycle after the item is taken. Throughput is one item
// per cycle; the single-port slot memory is touched at most once per item and
// its read is registered.
// The receiver has no way to stall; results must be taken when rsp_valid is high.
// APB port: max_stacks at 0x0, max_height at 0x4; write only while idle.
// Reset: the ring is emptied and both limits return to 16. Slot contents
// are not cleared and need no clearing pass.
module queue_of_bounded_stacks #(
   parameter int STACK_SLOTS = qbs_pkg::DEF_STACK_SLOTS,
   parameter int STACK_DEPTH = qbs_pkg::DEF_STACK_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_command,
   input  logic [qbs_pkg::DEST_W-1:0]   req_destination_in,
   input  logic [qbs_pkg::VALUE_W-1:0]  req_value_in,
   output logic                         rsp_valid,
   output logic                         rsp_accepted,
   output logic [qbs_pkg::DEST_W-1:0]   rsp_destination_out,
   output logic [qbs_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [qbs_pkg::PADDR_W-1:0]  paddr,
   input  logic [qbs_pkg::CSR_W-1:0]    pwdata,
   output logic [qbs_pkg::CSR_W-1:0]    prdata,
   output logic                         pready
);
   import qbs_pkg::*;

   localparam int WORDS  = STACK_SLOTS * STACK_DEPTH;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [LIMIT_W-1:0] max_stacks_ff, max_height_ff;
   logic               rsp_valid_ff;
   logic               accept, csr_wr;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_addr;
   logic [ITEM_W-1:0]  mem_rdata;
   status_type         status;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_stacks_ff <= RESET_MAX_STACKS;
         max_height_ff <= RESET_MAX_HEIGHT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (csr_wr && (paddr[2] == REG_MAX_STACKS)) begin
            max_stacks_ff <= pwdata[LIMIT_W-1:0];
         end
         if (csr_wr && (paddr[2] == REG_MAX_HEIGHT)) begin
            max_height_ff <= pwdata[LIMIT_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_MAX_HEIGHT) ? CSR_W'(max_height_ff)
                                                : CSR_W'(max_stacks_ff);

   qbs_ctrl #(
      .STACK_SLOTS (STACK_SLOTS),
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (accept),
      .op_cmd     (req_command),
      .max_stacks (max_stacks_ff),
      .max_height (max_height_ff),
      .mem_we     (mem_we),
      .mem_re     (mem_re),
      .mem_addr   (mem_addr),
      .status     (status)
   );

   qbs_mem #(
      .ADDR_W (ADDR_W),
      .WORDS  (WORDS)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata ({req_destination_in, req_value_in}),
      .rdata (mem_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = status.accepted;
   assign rsp_destination_out = status.shipped ? mem_rdata[ITEM_W-1:VALUE_W] : '0;
   assign rsp_value_out       = status.shipped ? mem_rdata[VALUE_W-1:0] : '0;
   assign rsp_is_empty        = status.is_empty;
   assign rsp_is_full         = status.is_full;

`ifndef SYNTHESIS
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("item taken without a result on the next cycle");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty && rsp_is_full))
      else $error("store reported empty and full at once");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> (rsp_value_out == '0) && (rsp_destination_out == '0))
      else $error("refused item carries payload");

   a_ship_on_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty && accept && (req_command == CMD_SHIP) |=> !rsp_accepted)
      else $error("ship accepted on an empty store");
`endif

endmodule

@@ verif/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import qbs_pkg::*;

   localparam int SLOTS       = DEF_STACK_SLOTS;
   localparam int DEPTH       = DEF_STACK_DEPTH;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                accepted;
      logic [DEST_W-1:0]   dest;
      logic [VALUE_W-1:0]  value;
      logic                empty;
      logic                full;
   } outcome_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_command = CMD_STORE;
   logic [DEST_W-1:0]   req_destination_in = '0;
   logic [VALUE_W-1:0]  req_value_in = '0;
   logic                rsp_valid;
   logic                rsp_accepted;
   logic [DEST_W-1:0]   rsp_destination_out;
   logic [VALUE_W-1:0]  rsp_value_out;
   logic                rsp_is_empty;
   logic                rsp_is_full;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [CSR_W-1:0]    pwdata = '0;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   // mirror of the store
   logic [ITEM_W-1:0]   held [SLOTS*DEPTH];
   int                  fill_of [SLOTS];
   int                  front_idx;
   int                  stacks_used;
   logic [LIMIT_W-1:0]  limit_stacks = RESET_MAX_STACKS;
   logic [LIMIT_W-1:0]  limit_height = RESET_MAX_HEIGHT;

   outcome_type         pending_results [$];
   outcome_type         oldest;
   int                  failures = 0;
   int                  cycle_count = 0;
   int                  idle_pct = 6;

   queue_of_bounded_stacks dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_destination_in  (req_destination_in),
      .req_value_in        (req_value_in),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_destination_out (rsp_destination_out),
      .rsp_value_out       (rsp_value_out),
      .rsp_is_empty        (rsp_is_empty),
      .rsp_is_full         (rsp_is_full),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int stack_cap();
      int v = int'(limit_stacks);
      if (v == 0) v = 1;
      if (v > SLOTS) v = SLOTS;
      return v;
   endfunction

   function automatic int height_cap();
      int v = int'(limit_height);
      if (v == 0) v = 1;
      if (v > DEPTH) v = DEPTH;
      return v;
   endfunction

   function automatic int back_of_ring();
      return (front_idx + stacks_used + SLOTS - 1) % SLOTS;
   endfunction

   function automatic logic ring_full();
      if (stacks_used == 0) return 1'b0;
      return stacks_used >= stack_cap() && fill_of[back_of_ring()] >= height_cap();
   endfunction

   function automatic outcome_type apply_command(input logic cmd, input logic [DEST_W-1:0] d,
                                                 input logic [VALUE_W-1:0] v);
      outcome_type r;
      int          s;
      r = '0;
      if (cmd == CMD_STORE) begin
         if (!ring_full()) begin
            if (stacks_used == 0 || fill_of[back_of_ring()] >= height_cap()) begin
               stacks_used++;
               s = back_of_ring();
               fill_of[s] = 0;
            end else begin
               s = back_of_ring();
            end
            held[s*DEPTH + fill_of[s]] = {d, v};
            fill_of[s]++;
            r.accepted = 1'b1;
         end
      end else if (stacks_used != 0) begin
         s = front_idx;
         if (fill_of[s] > 0) fill_of[s]--;
         {r.dest, r.value} = held[s*DEPTH + fill_of[s]];
         if (fill_of[s] == 0) begin
            front_idx = (s + 1) % SLOTS;
            stacks_used--;
         end
         r.accepted = 1'b1;
      end
      r.empty = (stacks_used == 0);
      r.full  = ring_full();
      return r;
   endfunction

   task automatic report_field(input string name, input logic [CSR_W-1:0] want,
                               input logic [CSR_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %b %h %h %b %b",
                     $time, rsp_accepted, rsp_destination_out, rsp_value_out,
                     rsp_is_empty, rsp_is_full);
            failures++;
         end else begin
            oldest = pending_results.pop_front();
            report_field("accepted", CSR_W'(oldest.accepted), CSR_W'(rsp_accepted));
            report_field("destination_out", CSR_W'(oldest.dest), CSR_W'(rsp_destination_out));
            report_field("value_out", oldest.value, rsp_value_out);
            report_field("is_empty", CSR_W'(oldest.empty), CSR_W'(rsp_is_empty));
            report_field("is_full", CSR_W'(oldest.full), CSR_W'(rsp_is_full));
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [DEST_W-1:0] d,
                            input logic [VALUE_W-1:0] v);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do begin
            req_command        <= 1'($urandom);
            req_destination_in <= DEST_W'($urandom);
            req_value_in       <= $urandom;
            @(posedge clock);
         end while ($urandom_range(99) < idle_pct);
      end
      start              <= 1'b1;
      req_command        <= cmd;
      req_destination_in <= d;
      req_value_in       <= v;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_command(cmd, d, v));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write then read back; only while idle
   task automatic set_limit(input logic sel, input logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (sel == REG_MAX_STACKS) limit_stacks = data[LIMIT_W-1:0];
      else limit_height = data[LIMIT_W-1:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      report_field(sel == REG_MAX_STACKS ? "max_stacks read" : "max_height read",
                   CSR_W'(data[LIMIT_W-1:0]), prdata);
   endtask

   task automatic set_limits(input logic [CSR_W-1:0] stacks, input logic [CSR_W-1:0] height);
      wait_drained();
      set_limit(REG_MAX_STACKS, stacks);
      set_limit(REG_MAX_HEIGHT, height);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_empty_ship();
      send_item(CMD_SHIP, 8'hff, 32'hffff_ffff);
      send_item(CMD_SHIP, 8'h00, 32'h0);
   endtask

   task automatic test_field_extremes();
      send_item(CMD_STORE, 8'h00, 32'h0000_0000);
      send_item(CMD_STORE, 8'hff, 32'hffff_ffff);
      send_item(CMD_STORE, 8'haa, 32'h5555_5555);
      send_item(CMD_STORE, 8'h55, 32'haaaa_aaaa);
      repeat (5) send_item(CMD_SHIP, DEST_W'($urandom), $urandom);
   endtask

   // zero acts as one; single slot fills at once
   task automatic test_tiny_limits();
      set_limits(1, 1);
      send_item(CMD_STORE, 8'h12, 32'h1234_5678);
      send_item(CMD_STORE, 8'h34, 32'h9abc_def0);
      send_item(CMD_SHIP, 8'h0, 32'h0);
      set_limits(0, 0);
      send_item(CMD_STORE, 8'h56, 32'h0f0f_0f0f);
      send_item(CMD_STORE, 8'h78, 32'hf0f0_f0f0);
      send_item(CMD_SHIP, 8'h0, 32'h0);
      send_item(CMD_SHIP, 8'h0, 32'h0);
   endtask

   // limits dropped below what is already held
   task automatic test_lowered_limits();
      set_limits(16, 16);
      repeat (5) send_item(CMD_STORE, DEST_W'($urandom), $urandom);
      set_limits(2, 2);
      repeat (3) send_item(CMD_STORE, DEST_W'($urandom), $urandom);
      repeat (8) send_item(CMD_SHIP, DEST_W'($urandom), $urandom);
   endtask

   task automatic test_random_traffic(input int count, input int store_bias);
      int   sent;
      int   run;
      logic kind;
      sent = 0;
      while (sent < count) begin
         kind = ($urandom_range(99) < store_bias) ? CMD_STORE : CMD_SHIP;
         run  = $urandom_range(24, 1);
         repeat (run) begin
            if ($urandom_range(99) < 10) begin
               send_item(1'($urandom), DEST_W'($urandom), $urandom);
            end else begin
               send_item(kind, DEST_W'($urandom), $urandom);
            end
            sent++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_ship();
      test_field_extremes();
      test_tiny_limits();
      test_lowered_limits();

      set_limits(16, 16);
      test_random_traffic(150, 65);
      set_limits(1, 1);
      test_random_traffic(150, 50);
      idle_pct = 68;
      set_limits(0, 3);
      test_random_traffic(150, 50);
      set_limits(($urandom & ~32'h1f) | 32'd31, ($urandom & ~32'h1f) | 32'd31);
      test_random_traffic(150, 70);
      idle_pct = 0;
      set_limits(2, 16);
      test_random_traffic(150, 40);
      set_limits($urandom, $urandom);
      test_random_traffic(150, 55);

      wait_drained();
      repeat (4) @(posedge clock);
      if (failures == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

@@ queue_of_bounded_stacks.f @@
rtl/core/qbs_pkg.sv
rtl/core/qbs_mem.sv
rtl/core/qbs_ctrl.sv
rtl/core/queue_of_bounded_stacks.sv
verif/tb_top.sv
